// ===== rtl/enlf_pkg.sv =====
package enlf_pkg;

   localparam int IMAGE_WIDTH_DEF  = 128;
   localparam int IMAGE_HEIGHT_DEF = 128;
   localparam int NEIGH_RADIUS_DEF = 3;

   localparam int COORD_W    = 7;
   localparam int TIME_W     = 32;
   localparam int WIDX_W     = 6;
   localparam int WVAL_W     = 13;
   localparam int POT_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int THR_W      = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int EXP_BITS   = 20;
   localparam int EXP_K_W    = 5;
   localparam int FACT_W     = 17;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAK      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY     = 2'd2;

   localparam logic signed [POT_W-1:0] NEG_HALF = -16'sd2048;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   function automatic logic [15:0] exp_rom(input logic [EXP_K_W-1:0] k);
      logic [15:0] v;
      case (k)
         5'd0:    v = 16'd65535;
         5'd1:    v = 16'd65534;
         5'd2:    v = 16'd65532;
         5'd3:    v = 16'd65528;
         5'd4:    v = 16'd65520;
         5'd5:    v = 16'd65504;
         5'd6:    v = 16'd65472;
         5'd7:    v = 16'd65408;
         5'd8:    v = 16'd65280;
         5'd9:    v = 16'd65026;
         5'd10:   v = 16'd64520;
         5'd11:   v = 16'd63520;
         5'd12:   v = 16'd61565;
         5'd13:   v = 16'd57835;
         5'd14:   v = 16'd51039;
         5'd15:   v = 16'd39750;
         5'd16:   v = 16'd24109;
         5'd17:   v = 16'd8869;
         5'd18:   v = 16'd1200;
         5'd19:   v = 16'd22;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/event_neighborhood_leaky_fire_unit.sv =====
// Leaky integrate-and-fire event filter. Each address event visits the square
// neighbourhood around its pixel, column offset outer and row offset inner, and
// every neighbour inside the image is decayed, given its weight and, if it
// reaches the threshold, reset to -0.5 and sent out as one result transfer;
// rsp_last marks the final result of an event. A weight load is written to the
// weight table when it is taken. All arithmetic runs through one shared 33 by 18
// bit multiplier. A neighbour whose product of decay_rate and elapsed ticks
// reaches 2^20 skips the exponential, a neighbour outside the image is passed
// over without a read, and a fired result waits while the result side has not
// taken the previous one. After reset the pixel stores are cleared in full
// before the first request is taken; register writes are taken throughout.
module event_neighborhood_leaky_fire_unit #(
   parameter int IMAGE_WIDTH  = enlf_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = enlf_pkg::IMAGE_HEIGHT_DEF,
   parameter int NEIGH_RADIUS = enlf_pkg::NEIGH_RADIUS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [enlf_pkg::COORD_W-1:0]      req_pixel_x,
   input  logic [enlf_pkg::COORD_W-1:0]      req_pixel_y,
   input  logic [enlf_pkg::TIME_W-1:0]       req_event_time,
   input  logic [enlf_pkg::WIDX_W-1:0]       req_weight_index,
   input  logic [enlf_pkg::WVAL_W-1:0]       req_weight_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [enlf_pkg::COORD_W-1:0]      rsp_fired_x,
   output logic [enlf_pkg::COORD_W-1:0]      rsp_fired_y,
   output logic                              rsp_last,
   input  logic                              csr_we,
   input  logic [enlf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [enlf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import enlf_pkg::*;

   localparam int SIDE      = 2 * NEIGH_RADIUS + 1;
   localparam int TBL_DEPTH = SIDE * SIDE;
   localparam int TAW       = $clog2(TBL_DEPTH);
   localparam int OW        = $clog2(SIDE);
   localparam int PIXELS    = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int AW        = $clog2(PIXELS);
   localparam int XW = (($clog2(IMAGE_WIDTH) > COORD_W) ? $clog2(IMAGE_WIDTH) : COORD_W) + 2;
   localparam int YW = (($clog2(IMAGE_HEIGHT) > COORD_W) ? $clog2(IMAGE_HEIGHT) : COORD_W) + 2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_READ, S_EXPCHK, S_EXP, S_EXPW,
      S_LEAK, S_LEAKW, S_POT, S_SUM, S_FLUSH
   } state_type;

   state_type               state_ff;
   logic [AW-1:0]           clr_ff;
   logic [COORD_W-1:0]      x0_ff, y0_ff;
   logic [TIME_W-1:0]       t_ff;
   logic [OW-1:0]           a_ff, b_ff;
   logic [TAW-1:0]          widx_ff;
   logic [AW-1:0]           pix_ff;
   logic [COORD_W-1:0]      nx_ff, ny_ff;
   logic [EXP_BITS-1:0]     e_ff;
   logic [EXP_K_W-1:0]      k_ff;
   logic [FACT_W-1:0]       f_ff, m_ff;
   logic [THR_W-1:0]        thr_ff;
   logic [GAIN_W-1:0]       leak_ff, decay_ff;
   logic                    pend_valid_ff;
   logic [COORD_W-1:0]      pend_x_ff, pend_y_ff;
   logic                    rsp_valid_ff, rsp_last_ff;
   logic [COORD_W-1:0]      rsp_x_ff, rsp_y_ff;

   logic signed [XW-1:0]    x_s;
   logic signed [YW-1:0]    y_s;
   logic                    in_img, last_neigh, advance, out_free, go, fire;
   logic [AW-1:0]           pix;
   logic [TIME_W-1:0]       elapsed;
   mul_req_type             mreq;
   logic signed [MUL_P_W-1:0] prod_ff, rnd;
   logic signed [FACT_W-1:0]  decayed;
   logic signed [17:0]      sum_raw, sum_sat;
   logic [POT_W-1:0]        pot_rd, pot_wd;
   logic [TIME_W-1:0]       time_rd, time_wd;
   logic [WVAL_W-1:0]       weight_rd;
   logic                    px_we, px_re, w_we;
   logic [AW-1:0]           px_waddr;
   logic                    accept;
   logic                    rsp_load;

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_fired_x = rsp_x_ff;
   assign rsp_fired_y = rsp_y_ff;
   assign rsp_last    = rsp_last_ff;

   always_comb begin
      x_s = $signed(XW'(x0_ff)) - $signed(XW'(NEIGH_RADIUS)) + $signed(XW'(a_ff));
      y_s = $signed(YW'(y0_ff)) - $signed(YW'(NEIGH_RADIUS)) + $signed(YW'(b_ff));
      in_img = (x_s >= 0) && (x_s < $signed(XW'(IMAGE_WIDTH)))
               && (y_s >= 0) && (y_s < $signed(YW'(IMAGE_HEIGHT)));
      pix = AW'(32'($unsigned(y_s)) * 32'(IMAGE_WIDTH) + 32'($unsigned(x_s)));
      last_neigh = (a_ff == OW'(SIDE - 1)) && (b_ff == OW'(SIDE - 1));
      elapsed = (t_ff >= time_rd) ? (t_ff - time_rd) : '0;

      mreq.a = '0;
      mreq.b = '0;
      case (state_ff)
         S_READ: begin
            mreq.a = $signed({1'b0, elapsed});
            mreq.b = $signed({2'b0, decay_ff});
         end
         S_EXP: begin
            mreq.a = $signed(MUL_A_W'(f_ff));
            mreq.b = $signed({2'b0, exp_rom(k_ff)});
         end
         S_LEAK: begin
            mreq.a = $signed(MUL_A_W'(f_ff));
            mreq.b = $signed({2'b0, leak_ff});
         end
         S_POT, S_SUM: begin
            mreq.a = MUL_A_W'($signed(pot_rd));
            mreq.b = $signed({1'b0, m_ff});
         end
         default: begin
            mreq.a = '0;
            mreq.b = '0;
         end
      endcase

      rnd     = prod_ff + $signed(MUL_P_W'(32768));
      decayed = rnd[32:16];
      sum_raw = 18'($signed(decayed)) + $signed({5'b0, weight_rd});
      sum_sat = (sum_raw > 18'sd32767) ? 18'sd32767 : sum_raw;
      fire    = sum_sat >= $signed({3'b0, thr_ff});

      out_free = !rsp_valid_ff || rsp_ready;
      go       = !fire || !pend_valid_ff || out_free;
      advance  = ((state_ff == S_ADDR) && !in_img) || ((state_ff == S_SUM) && go);
      rsp_load = ((state_ff == S_SUM) && go && fire && pend_valid_ff)
                 || ((state_ff == S_FLUSH) && pend_valid_ff && out_free);

      px_we    = (state_ff == S_CLEAR) || ((state_ff == S_SUM) && go);
      px_waddr = (state_ff == S_CLEAR) ? clr_ff : pix_ff;
      pot_wd   = (state_ff == S_CLEAR) ? '0 : (fire ? NEG_HALF : sum_sat[POT_W-1:0]);
      time_wd  = (state_ff == S_CLEAR) ? '0 : t_ff;
      px_re    = (state_ff == S_ADDR) && in_img;
      w_we     = accept && req_action && (req_weight_index < WIDX_W'(TBL_DEPTH));
   end

   enlf_mul u_mul (
      .clock   (clock),
      .req     (mreq),
      .prod_ff (prod_ff)
   );

   enlf_ram #(.WIDTH(POT_W), .DEPTH(PIXELS)) u_pot_ram (
      .clock    (clock),
      .we       (px_we),
      .waddr    (px_waddr),
      .wdata    (pot_wd),
      .re       (px_re),
      .raddr    (pix),
      .rdata_ff (pot_rd)
   );

   enlf_ram #(.WIDTH(TIME_W), .DEPTH(PIXELS)) u_time_ram (
      .clock    (clock),
      .we       (px_we),
      .waddr    (px_waddr),
      .wdata    (time_wd),
      .re       (px_re),
      .raddr    (pix),
      .rdata_ff (time_rd)
   );

   enlf_ram #(.WIDTH(WVAL_W), .DEPTH(TBL_DEPTH)) u_weight_ram (
      .clock    (clock),
      .we       (w_we),
      .waddr    (req_weight_index[TAW-1:0]),
      .wdata    (req_weight_value),
      .re       (px_re),
      .raddr    (widx_ff),
      .rdata_ff (weight_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= THR_W'(4096);
         leak_ff       <= GAIN_W'(65535);
         decay_ff      <= GAIN_W'(65);
         a_ff          <= '0;
         b_ff          <= '0;
         widx_ff       <= '0;
         k_ff          <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff   <= csr_wdata[THR_W-1:0];
               CSR_LEAK:      leak_ff  <= csr_wdata;
               CSR_DECAY:     decay_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            widx_ff <= widx_ff + TAW'(1);
            if (b_ff == OW'(SIDE - 1)) begin
               b_ff <= '0;
               a_ff <= a_ff + OW'(1);
            end else begin
               b_ff <= b_ff + OW'(1);
            end
         end

         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(PIXELS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept && !req_action) begin
                  x0_ff    <= req_pixel_x;
                  y0_ff    <= req_pixel_y;
                  t_ff     <= req_event_time;
                  a_ff     <= '0;
                  b_ff     <= '0;
                  widx_ff  <= '0;
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: begin
               pix_ff <= pix;
               nx_ff  <= x_s[COORD_W-1:0];
               ny_ff  <= y_s[COORD_W-1:0];
               if (in_img) begin
                  state_ff <= S_READ;
               end else if (last_neigh) begin
                  state_ff <= S_FLUSH;
               end
            end
            S_READ: begin
               state_ff <= S_EXPCHK;
            end
            S_EXPCHK: begin
               k_ff <= '0;
               if (|prod_ff[MUL_P_W-1:EXP_BITS]) begin
                  f_ff     <= '0;
                  state_ff <= S_LEAK;
               end else begin
                  e_ff     <= prod_ff[EXP_BITS-1:0];
                  f_ff     <= FACT_W'(65536);
                  state_ff <= S_EXP;
               end
            end
            S_EXP: begin
               if (k_ff == EXP_K_W'(EXP_BITS)) begin
                  state_ff <= S_LEAK;
               end else if (e_ff[k_ff]) begin
                  state_ff <= S_EXPW;
               end else begin
                  k_ff <= k_ff + EXP_K_W'(1);
               end
            end
            S_EXPW: begin
               f_ff     <= rnd[32:16];
               k_ff     <= k_ff + EXP_K_W'(1);
               state_ff <= S_EXP;
            end
            S_LEAK: begin
               state_ff <= S_LEAKW;
            end
            S_LEAKW: begin
               m_ff     <= rnd[32:16];
               state_ff <= S_POT;
            end
            S_POT: begin
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (go) begin
                  if (fire) begin
                     pend_valid_ff <= 1'b1;
                     pend_x_ff     <= nx_ff;
                     pend_y_ff     <= ny_ff;
                     if (pend_valid_ff) begin
                        rsp_x_ff     <= pend_x_ff;
                        rsp_y_ff     <= pend_y_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                  end
                  state_ff <= last_neigh ? S_FLUSH : S_ADDR;
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  rsp_x_ff      <= pend_x_ff;
                  rsp_y_ff      <= pend_y_ff;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left over at the end of an event");

   a_exp_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP || state_ff == S_EXPW) |-> (k_ff <= EXP_K_W'(EXP_BITS)))
      else $error("exponential step index out of range");

   a_flush_gives_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH && pend_valid_ff && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final result of an event not marked as last");
`endif

endmodule

// ===== rtl/enlf_mul.sv =====
module enlf_mul (
   input  logic                                 clock,
   input  enlf_pkg::mul_req_type                req,
   output logic signed [enlf_pkg::MUL_P_W-1:0]  prod_ff
);
   import enlf_pkg::*;

   always_ff @(posedge clock) begin
      prod_ff <= req.a * req.b;
   end

endmodule

// ===== rtl/enlf_ram.sv =====
module enlf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule
